[sv/hbs_pkg.sv]
package hbs_pkg;

    // Store geometry. The store is addressed as {row, column}.
    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLUMNS = 256;
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int ADDR_BITS   = ROW_BITS + COL_BITS;

    // Field widths.
    localparam int COUNT_BITS  = 9;
    localparam int SAMPLE_BITS = 8;
    localparam int LOW_BITS    = 9;
    localparam int COORD_BITS  = 20;
    localparam int HEIGHT_BITS = 16;

    // One grid cell spans ten world units in Q.8, that is 10 << 8.
    localparam int CELL_SPAN   = 2560;
    localparam int CELL_SHIFT  = 8;
    localparam int POS_BITS    = 22;
    localparam int GRID_BITS   = 20;
    localparam int TENTH_BITS  = GRID_BITS - CELL_SHIFT;
    localparam int FRAC_BITS   = 12;

    // Division by ten as a multiply by a reciprocal; exact for dividends below 16384.
    localparam int RECIP10       = 3277;
    localparam int RECIP10_SHIFT = 15;
    localparam int PROD10_BITS   = 24;

    // The blend divisor 51200 is 25 << 11; division by 25 is exact below 2**20.
    localparam int BLEND_SHIFT   = 11;
    localparam int RECIP25       = 1342178;
    localparam int RECIP25_SHIFT = 25;
    localparam int SCALE_BITS    = 41;
    localparam int QUOT_BITS     = SCALE_BITS - RECIP25_SHIFT;

    localparam int HALF_BITS     = 10;
    localparam int HALF_OFFSET   = 10;
    localparam int WEIGHT_BITS   = 24;
    localparam int ACC_BITS      = 32;
    localparam int HEIGHT_LIMIT  = 2 ** (HEIGHT_BITS - 1);

    localparam int LOWEST_RESET  = 256;
    localparam int COUNT_RESET   = 256;

    // Blend sequencing: four corner reads, then drain steps up to SUM_LAST that empty the pipeline.
    localparam int STEP_BITS     = 3;
    localparam int CORNERS       = 4;
    localparam int SUM_LAST      = 5;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 1'b1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                          mode;
        logic                          start_of_map;
        logic [7:0]                    grid_row;
        logic [7:0]                    grid_column;
        logic [SAMPLE_BITS-1:0]        sample_value;
        logic signed [COORD_BITS-1:0]  query_x;
        logic signed [COORD_BITS-1:0]  query_z;
    } in_word_t;

    typedef struct packed {
        logic signed [HEIGHT_BITS-1:0] height;
        logic                          outside;
    } out_word_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]  iz;
        logic [COL_BITS-1:0]  ix;
        logic [FRAC_BITS-1:0] fz;
        logic [FRAC_BITS-1:0] fx;
    } cell_t;

    typedef struct packed {
        logic load;
        logic recip;
        logic frac;
    } coord_ctrl_t;

    typedef struct packed {
        logic       clear;
        logic       weight_en;
        logic       mul_en;
        logic       acc_en;
        logic       scale_en;
        logic [1:0] corner;
    } blend_ctrl_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RECIP = 6'b000010,
        ST_FRAC  = 6'b000100,
        ST_SUM   = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

[sv/hbs_sample_ram.sv]
module hbs_sample_ram (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [hbs_pkg::ADDR_BITS-1:0]   wr_addr,
    input  logic [hbs_pkg::SAMPLE_BITS-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [hbs_pkg::ADDR_BITS-1:0]   rd_addr,
    output logic [hbs_pkg::SAMPLE_BITS-1:0] rd_data
);

    logic [hbs_pkg::SAMPLE_BITS-1:0] mem [0:hbs_pkg::MAX_ROWS*hbs_pkg::MAX_COLUMNS-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/hbs_coord_unit.sv]
module hbs_coord_unit (
    input  logic                                  aclk,
    input  hbs_pkg::coord_ctrl_t                  ctrl,
    input  logic signed [hbs_pkg::COORD_BITS-1:0] query_x,
    input  logic signed [hbs_pkg::COORD_BITS-1:0] query_z,
    input  logic [hbs_pkg::COUNT_BITS-1:0]        row_count,
    input  logic [hbs_pkg::COUNT_BITS-1:0]        column_count,
    output hbs_pkg::cell_t                        grid_cell,
    output logic                                  outside
);

    function automatic logic signed [hbs_pkg::POS_BITS-1:0] grid_pos(
        input logic signed [hbs_pkg::COORD_BITS-1:0] q,
        input logic [hbs_pkg::COUNT_BITS-1:0]        count
    );
        logic [hbs_pkg::POS_BITS-1:0] offset;
        offset = hbs_pkg::POS_BITS'(count[hbs_pkg::COUNT_BITS-1:1])
               * hbs_pkg::POS_BITS'(hbs_pkg::CELL_SPAN);
        grid_pos = hbs_pkg::POS_BITS'(q) + $signed(offset);
    endfunction

    function automatic logic off_axis(
        input logic signed [hbs_pkg::POS_BITS-1:0] pos,
        input logic [hbs_pkg::COUNT_BITS-1:0]      count
    );
        logic [hbs_pkg::POS_BITS-1:0] limit;
        limit = (hbs_pkg::POS_BITS'(count) - hbs_pkg::POS_BITS'(1))
              * hbs_pkg::POS_BITS'(hbs_pkg::CELL_SPAN);
        off_axis = (count < hbs_pkg::COUNT_BITS'(2)) || pos[hbs_pkg::POS_BITS-1]
                || ($unsigned(pos) >= limit);
    endfunction

    logic signed [hbs_pkg::POS_BITS-1:0] gx;
    logic signed [hbs_pkg::POS_BITS-1:0] gz;
    logic [hbs_pkg::GRID_BITS-1:0]       pos_x_reg;
    logic [hbs_pkg::GRID_BITS-1:0]       pos_z_reg;
    logic                                outside_reg;
    logic [hbs_pkg::PROD10_BITS-1:0]     tenth_x_reg;
    logic [hbs_pkg::PROD10_BITS-1:0]     tenth_z_reg;
    logic [hbs_pkg::COL_BITS-1:0]        ix;
    logic [hbs_pkg::ROW_BITS-1:0]        iz;
    logic [hbs_pkg::GRID_BITS-1:0]       diff_x;
    logic [hbs_pkg::GRID_BITS-1:0]       diff_z;
    hbs_pkg::cell_t                      cell_reg;

    assign gx = grid_pos(query_x, column_count);
    assign gz = grid_pos(query_z, row_count);

    // The cell index is the quotient of the position by the span; the
    // fraction is what is left after subtracting index times span.
    assign ix = tenth_x_reg[hbs_pkg::RECIP10_SHIFT +: hbs_pkg::COL_BITS];
    assign iz = tenth_z_reg[hbs_pkg::RECIP10_SHIFT +: hbs_pkg::ROW_BITS];
    assign diff_x = pos_x_reg
                  - hbs_pkg::GRID_BITS'(ix) * hbs_pkg::GRID_BITS'(hbs_pkg::CELL_SPAN);
    assign diff_z = pos_z_reg
                  - hbs_pkg::GRID_BITS'(iz) * hbs_pkg::GRID_BITS'(hbs_pkg::CELL_SPAN);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            pos_x_reg   <= gx[hbs_pkg::GRID_BITS-1:0];
            pos_z_reg   <= gz[hbs_pkg::GRID_BITS-1:0];
            outside_reg <= off_axis(gx, column_count) || off_axis(gz, row_count);
        end
        if (ctrl.recip) begin
            tenth_x_reg <= hbs_pkg::PROD10_BITS'(pos_x_reg[hbs_pkg::GRID_BITS-1:hbs_pkg::CELL_SHIFT])
                         * hbs_pkg::PROD10_BITS'(hbs_pkg::RECIP10);
            tenth_z_reg <= hbs_pkg::PROD10_BITS'(pos_z_reg[hbs_pkg::GRID_BITS-1:hbs_pkg::CELL_SHIFT])
                         * hbs_pkg::PROD10_BITS'(hbs_pkg::RECIP10);
        end
        if (ctrl.frac) begin
            cell_reg.ix <= ix;
            cell_reg.iz <= iz;
            cell_reg.fx <= diff_x[hbs_pkg::FRAC_BITS-1:0];
            cell_reg.fz <= diff_z[hbs_pkg::FRAC_BITS-1:0];
        end
    end

    assign grid_cell = cell_reg;
    assign outside   = outside_reg;

endmodule

[sv/hbs_blend_unit.sv]
module hbs_blend_unit (
    input  logic                                   aclk,
    input  hbs_pkg::blend_ctrl_t                   ctrl,
    input  hbs_pkg::cell_t                         grid_cell,
    input  logic [hbs_pkg::SAMPLE_BITS-1:0]        sample,
    input  logic [hbs_pkg::LOW_BITS-1:0]           lowest,
    output logic signed [hbs_pkg::HEIGHT_BITS-1:0] height
);

    logic [hbs_pkg::FRAC_BITS-1:0]         ex;
    logic [hbs_pkg::FRAC_BITS-1:0]         ez;
    logic [hbs_pkg::FRAC_BITS-1:0]         wa;
    logic [hbs_pkg::FRAC_BITS-1:0]         wb;
    logic signed [hbs_pkg::HALF_BITS-1:0]  half_h;
    logic [hbs_pkg::ACC_BITS-1:0]          mag;
    logic [hbs_pkg::QUOT_BITS-1:0]         quot;
    logic [hbs_pkg::WEIGHT_BITS-1:0]       w_reg;
    logic signed [hbs_pkg::ACC_BITS-1:0]   prod_reg;
    logic signed [hbs_pkg::ACC_BITS-1:0]   acc_reg;
    logic [hbs_pkg::SCALE_BITS-1:0]        scale_reg;
    logic                                  neg_reg;

    assign ex = hbs_pkg::FRAC_BITS'(hbs_pkg::CELL_SPAN) - grid_cell.fx;
    assign ez = hbs_pkg::FRAC_BITS'(hbs_pkg::CELL_SPAN) - grid_cell.fz;
    assign wa = ctrl.corner[1] ? grid_cell.fx : ex;
    assign wb = ctrl.corner[0] ? grid_cell.fz : ez;

    // Sample height in half units: sample minus the map minimum minus ten.
    assign half_h = hbs_pkg::HALF_BITS'(sample) - hbs_pkg::HALF_BITS'(lowest)
                  - hbs_pkg::HALF_BITS'(hbs_pkg::HALF_OFFSET);

    // Truncation toward zero is done on the magnitude, then the sign is restored.
    assign mag  = acc_reg[hbs_pkg::ACC_BITS-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    assign quot = scale_reg[hbs_pkg::SCALE_BITS-1:hbs_pkg::RECIP25_SHIFT];

    always_comb begin
        if (neg_reg) begin
            if (hbs_pkg::QUOT_BITS'(hbs_pkg::HEIGHT_LIMIT) < quot) begin
                height = hbs_pkg::HEIGHT_BITS'(hbs_pkg::HEIGHT_LIMIT);
            end else begin
                height = hbs_pkg::HEIGHT_BITS'(-quot);
            end
        end else begin
            if (quot >= hbs_pkg::QUOT_BITS'(hbs_pkg::HEIGHT_LIMIT)) begin
                height = hbs_pkg::HEIGHT_BITS'(hbs_pkg::HEIGHT_LIMIT - 1);
            end else begin
                height = $signed(quot);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.weight_en) begin
            w_reg <= hbs_pkg::WEIGHT_BITS'(wa) * hbs_pkg::WEIGHT_BITS'(wb);
        end
        if (ctrl.mul_en) begin
            prod_reg <= hbs_pkg::ACC_BITS'(half_h)
                      * hbs_pkg::ACC_BITS'($signed({1'b0, w_reg}));
        end
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (ctrl.scale_en) begin
            neg_reg   <= acc_reg[hbs_pkg::ACC_BITS-1];
            scale_reg <= hbs_pkg::SCALE_BITS'(mag[hbs_pkg::ACC_BITS-2:hbs_pkg::BLEND_SHIFT])
                       * hbs_pkg::SCALE_BITS'(hbs_pkg::RECIP25);
        end
    end

endmodule

[sv/heightmap_bilinear_sampler_unit.sv]
// Height-map sampler. A load word writes one 8-bit sample into the 256 x 256 sample
// memory and updates the running map minimum; loads are taken one per cycle while
// idle and give no result. A query word returns one result word: the bilinear
// height in signed Q.8, or zero with the outside flag. Inside the grid a query runs
// through the reciprocal, fraction, sum, scale and done states; done registers the
// result once the output register is free, and the input is ready again in the
// cycle the result is presented. Query time is set by the four corner reads issued
// one per cycle on the single read port of the sample memory plus the coordinate
// division and final scaling steps. An outside query goes from the reciprocal state
// straight to done. No new word is taken while a query is in progress, but a word
// is taken while a finished result waits on the output register. The sample memory
// is not cleared after reset: query only cells that have been loaded.
module heightmap_bilinear_sampler_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  hbs_pkg::in_word_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output hbs_pkg::out_word_t                    m_data,
    input  logic                                  cfg_we,
    input  logic [hbs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [hbs_pkg::COUNT_BITS-1:0]        cfg_data
);

    hbs_pkg::state_t                   state_reg, state_next;
    logic [hbs_pkg::STEP_BITS-1:0]     step_reg, step_next;
    logic [hbs_pkg::LOW_BITS-1:0]      lowest_reg, lowest_next;
    logic [hbs_pkg::COUNT_BITS-1:0]    row_count_reg, row_count_next;
    logic [hbs_pkg::COUNT_BITS-1:0]    column_count_reg, column_count_next;
    logic                              m_valid_reg, m_valid_next;
    hbs_pkg::out_word_t                m_data_reg;

    logic                              load_fire;
    logic                              query_fire;
    logic                              done_fire;
    logic [hbs_pkg::COUNT_BITS-1:0]    rows_used;
    logic [hbs_pkg::COUNT_BITS-1:0]    cols_used;
    logic                              wr_en;
    logic [hbs_pkg::ADDR_BITS-1:0]     wr_addr;
    logic                              rd_en;
    logic [hbs_pkg::ADDR_BITS-1:0]     rd_addr;
    logic [hbs_pkg::SAMPLE_BITS-1:0]   rd_data;
    logic [hbs_pkg::ROW_BITS-1:0]      rd_row;
    logic [hbs_pkg::COL_BITS-1:0]      rd_col;
    logic                              in_sum;

    hbs_pkg::coord_ctrl_t              coord_ctrl;
    hbs_pkg::blend_ctrl_t              blend_ctrl;
    hbs_pkg::cell_t                    grid_cell;
    logic                              outside;
    logic signed [hbs_pkg::HEIGHT_BITS-1:0] blend_height;

    assign s_ready    = (state_reg == hbs_pkg::ST_IDLE);
    assign load_fire  = s_valid && s_ready && (s_data.mode == hbs_pkg::MODE_LOAD);
    assign query_fire = s_valid && s_ready && (s_data.mode == hbs_pkg::MODE_QUERY);
    assign done_fire  = (state_reg == hbs_pkg::ST_DONE) && (!m_valid_reg || m_ready);
    assign in_sum     = (state_reg == hbs_pkg::ST_SUM);

    assign rows_used = (row_count_reg > hbs_pkg::COUNT_BITS'(hbs_pkg::MAX_ROWS))
                     ? hbs_pkg::COUNT_BITS'(hbs_pkg::MAX_ROWS) : row_count_reg;
    assign cols_used = (column_count_reg > hbs_pkg::COUNT_BITS'(hbs_pkg::MAX_COLUMNS))
                     ? hbs_pkg::COUNT_BITS'(hbs_pkg::MAX_COLUMNS) : column_count_reg;

    // A load beyond the store writes nothing but still counts toward the minimum.
    assign wr_en   = load_fire
                  && (hbs_pkg::COUNT_BITS'(s_data.grid_row) < hbs_pkg::COUNT_BITS'(hbs_pkg::MAX_ROWS))
                  && (hbs_pkg::COUNT_BITS'(s_data.grid_column)
                      < hbs_pkg::COUNT_BITS'(hbs_pkg::MAX_COLUMNS));
    assign wr_addr = {hbs_pkg::ROW_BITS'(s_data.grid_row), hbs_pkg::COL_BITS'(s_data.grid_column)};

    // Corner k is read at step k; its data meets its weight at step k+1 and is
    // accumulated at step k+2. Loads are never accepted while a query runs, so
    // reads and writes of the same entry cannot overlap.
    assign blend_ctrl.corner    = step_reg[1:0];
    assign blend_ctrl.clear     = (state_reg == hbs_pkg::ST_FRAC);
    assign blend_ctrl.weight_en = in_sum && (step_reg < hbs_pkg::STEP_BITS'(hbs_pkg::CORNERS));
    assign blend_ctrl.mul_en    = in_sum && (step_reg >= hbs_pkg::STEP_BITS'(1))
                               && (step_reg <= hbs_pkg::STEP_BITS'(hbs_pkg::CORNERS));
    assign blend_ctrl.acc_en    = in_sum && (step_reg >= hbs_pkg::STEP_BITS'(2));
    assign blend_ctrl.scale_en  = (state_reg == hbs_pkg::ST_SCALE);

    assign coord_ctrl.load  = query_fire;
    assign coord_ctrl.recip = (state_reg == hbs_pkg::ST_RECIP);
    assign coord_ctrl.frac  = (state_reg == hbs_pkg::ST_FRAC);

    assign rd_en   = blend_ctrl.weight_en;
    assign rd_row  = grid_cell.iz + hbs_pkg::ROW_BITS'(blend_ctrl.corner[0]);
    assign rd_col  = grid_cell.ix + hbs_pkg::COL_BITS'(blend_ctrl.corner[1]);
    assign rd_addr = {rd_row, rd_col};

    hbs_sample_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.sample_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hbs_coord_unit u_coord (
        .aclk         (aclk),
        .ctrl         (coord_ctrl),
        .query_x      (s_data.query_x),
        .query_z      (s_data.query_z),
        .row_count    (rows_used),
        .column_count (cols_used),
        .grid_cell    (grid_cell),
        .outside      (outside)
    );

    hbs_blend_unit u_blend (
        .aclk      (aclk),
        .ctrl      (blend_ctrl),
        .grid_cell (grid_cell),
        .sample    (rd_data),
        .lowest    (lowest_reg),
        .height    (blend_height)
    );

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            hbs_pkg::ST_IDLE: begin
                if (query_fire) begin
                    state_next = hbs_pkg::ST_RECIP;
                end
            end
            hbs_pkg::ST_RECIP: begin
                state_next = outside ? hbs_pkg::ST_DONE : hbs_pkg::ST_FRAC;
            end
            hbs_pkg::ST_FRAC: begin
                state_next = hbs_pkg::ST_SUM;
                step_next  = '0;
            end
            hbs_pkg::ST_SUM: begin
                if (step_reg == hbs_pkg::STEP_BITS'(hbs_pkg::SUM_LAST)) begin
                    state_next = hbs_pkg::ST_SCALE;
                end else begin
                    step_next = step_reg + hbs_pkg::STEP_BITS'(1);
                end
            end
            hbs_pkg::ST_SCALE: begin
                state_next = hbs_pkg::ST_DONE;
            end
            hbs_pkg::ST_DONE: begin
                if (done_fire) begin
                    state_next = hbs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        lowest_next = lowest_reg;
        if (load_fire && (s_data.start_of_map
                          || (hbs_pkg::LOW_BITS'(s_data.sample_value) < lowest_reg))) begin
            lowest_next = hbs_pkg::LOW_BITS'(s_data.sample_value);
        end
    end

    always_comb begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        if (cfg_we) begin
            case (cfg_index)
                hbs_pkg::REG_ROW_COUNT:    row_count_next    = cfg_data;
                hbs_pkg::REG_COLUMN_COUNT: column_count_next = cfg_data;
                default: begin
                    row_count_next = row_count_reg;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (done_fire) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= hbs_pkg::ST_IDLE;
            step_reg         <= '0;
            lowest_reg       <= hbs_pkg::LOW_BITS'(hbs_pkg::LOWEST_RESET);
            row_count_reg    <= hbs_pkg::COUNT_BITS'(hbs_pkg::COUNT_RESET);
            column_count_reg <= hbs_pkg::COUNT_BITS'(hbs_pkg::COUNT_RESET);
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            lowest_reg       <= lowest_next;
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_fire) begin
            m_data_reg.height  <= outside ? '0 : blend_height;
            m_data_reg.outside <= outside;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        query_fire |=> (state_reg == hbs_pkg::ST_RECIP))
        else $error("query word accepted but sequencer did not start");

    assert property (@(posedge aclk) disable iff (!aresetn)
        load_fire |=> (state_reg == hbs_pkg::ST_IDLE) && !$rose(m_valid_reg))
        else $error("load word disturbed the sequencer or the result register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == hbs_pkg::ST_DONE))
        else $error("result word appeared without a finished query");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_sum |-> (step_reg <= hbs_pkg::STEP_BITS'(hbs_pkg::SUM_LAST)))
        else $error("blend step counter ran past its last step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == hbs_pkg::ST_DONE) && m_valid_reg && !m_ready)
        |=> (state_reg == hbs_pkg::ST_DONE))
        else $error("finished query left its state while the result register was full");

endmodule

[tb/sv/hbs_sampler_check_pkg.sv]
package hbs_sampler_check_pkg;
    import hbs_pkg::*;

    // The exact blend is divided by 2560 * 2560 / 128 to land in Q.8.
    localparam longint BLEND_DIVISOR = CELL_SPAN * CELL_SPAN / 128;

    class height_scoreboard;
        logic [SAMPLE_BITS-1:0] sample_mem [MAX_ROWS*MAX_COLUMNS];
        bit                     sample_set [MAX_ROWS*MAX_COLUMNS];
        logic [LOW_BITS-1:0]    lowest;
        logic [COUNT_BITS-1:0]  row_count;
        logic [COUNT_BITS-1:0]  column_count;
        out_word_t              awaited_heights[$];
        int                     mismatches;

        function new();
            lowest       = LOW_BITS'(LOWEST_RESET);
            row_count    = COUNT_BITS'(COUNT_RESET);
            column_count = COUNT_BITS'(COUNT_RESET);
            mismatches   = 0;
            foreach (sample_set[i]) sample_set[i] = 1'b0;
        endfunction

        function void set_count(logic [CFG_INDEX_BITS-1:0] index,
                                logic [COUNT_BITS-1:0] value);
            if (index == REG_ROW_COUNT) begin
                row_count = value;
            end else begin
                column_count = value;
            end
        endfunction

        function longint clamp_count(logic [COUNT_BITS-1:0] count, int limit);
            return (count < limit) ? longint'(count) : longint'(limit);
        endfunction

        // Maps a world point onto its cell and fraction; 0 when it is off the grid.
        function bit find_cell(logic signed [COORD_BITS-1:0] qx,
                               logic signed [COORD_BITS-1:0] qz,
                               output int ix, output int iz,
                               output int fx, output int fz);
            longint rows, cols, gx, gz;
            rows = clamp_count(row_count, MAX_ROWS);
            cols = clamp_count(column_count, MAX_COLUMNS);
            gx   = longint'(qx) + (cols / 2) * CELL_SPAN;
            gz   = longint'(qz) + (rows / 2) * CELL_SPAN;
            ix = 0;
            iz = 0;
            fx = 0;
            fz = 0;
            if (gx < 0 || gx >= (cols - 1) * CELL_SPAN ||
                gz < 0 || gz >= (rows - 1) * CELL_SPAN) begin
                return 1'b0;
            end
            ix = int'(gx / CELL_SPAN);
            iz = int'(gz / CELL_SPAN);
            fx = int'(gx % CELL_SPAN);
            fz = int'(gz % CELL_SPAN);
            return 1'b1;
        endfunction

        function longint half_height(int r, int c);
            return longint'(sample_mem[r*MAX_COLUMNS + c]) - longint'(lowest) - HALF_OFFSET;
        endfunction

        // True when a query would touch only loaded samples, or none at all.
        function bit query_is_defined(logic signed [COORD_BITS-1:0] qx,
                                      logic signed [COORD_BITS-1:0] qz);
            int ix, iz, fx, fz;
            if (!find_cell(qx, qz, ix, iz, fx, fz)) begin
                return 1'b1;
            end
            return sample_set[iz*MAX_COLUMNS + ix] && sample_set[iz*MAX_COLUMNS + ix + 1] &&
                   sample_set[(iz+1)*MAX_COLUMNS + ix] &&
                   sample_set[(iz+1)*MAX_COLUMNS + ix + 1];
        endfunction

        function void note_word(in_word_t w);
            int        ix, iz, fx, fz, addr;
            longint    acc, val;
            out_word_t e;
            if (w.mode == MODE_LOAD) begin
                addr = int'(w.grid_row) * MAX_COLUMNS + int'(w.grid_column);
                sample_mem[addr] = w.sample_value;
                sample_set[addr] = 1'b1;
                if (w.start_of_map || w.sample_value < lowest) begin
                    lowest = LOW_BITS'(w.sample_value);
                end
            end else begin
                e = '0;
                if (!find_cell($signed(w.query_x), $signed(w.query_z), ix, iz, fx, fz)) begin
                    e.outside = 1'b1;
                end else begin
                    acc = half_height(iz, ix) * (CELL_SPAN - fx) * (CELL_SPAN - fz)
                        + half_height(iz + 1, ix) * (CELL_SPAN - fx) * fz
                        + half_height(iz, ix + 1) * fx * (CELL_SPAN - fz)
                        + half_height(iz + 1, ix + 1) * fx * fz;
                    val = acc / BLEND_DIVISOR;
                    if (val >= HEIGHT_LIMIT) val = HEIGHT_LIMIT - 1;
                    if (val < -HEIGHT_LIMIT) val = -HEIGHT_LIMIT;
                    e.height = val[HEIGHT_BITS-1:0];
                end
                awaited_heights.push_back(e);
            end
        endfunction

        function void check_word(out_word_t got);
            out_word_t e;
            if (awaited_heights.size() == 0) begin
                $error("unexpected result word: height %0d outside %0b",
                       $signed(got.height), got.outside);
                mismatches++;
            end else begin
                e = awaited_heights.pop_front();
                if (got.height !== e.height) begin
                    $error("height: expected %0d, actual %0d",
                           $signed(e.height), $signed(got.height));
                    mismatches++;
                end
                if (got.outside !== e.outside) begin
                    $error("outside: expected %0b, actual %0b", e.outside, got.outside);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return awaited_heights.size();
        endfunction
    endclass

endpackage

[tb/sv/tb_heightmap_bilinear_sampler_unit.sv]
module tb_heightmap_bilinear_sampler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hbs_pkg::*;
    import hbs_sampler_check_pkg::*;

    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 2000;
    localparam int TOTAL_WORDS   = 800;
    localparam int CALM_AFTER    = 700;
    localparam int EDGE_FRAC     = CELL_SPAN - 1;
    localparam int COUNT_TOP     = (1 << COUNT_BITS) - 1;
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    in_word_t                  s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    out_word_t                 m_data;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_ROW_COUNT;
    logic [COUNT_BITS-1:0]     cfg_data  = '0;

    height_scoreboard sb = new();
    int cur_rows = COUNT_RESET;
    int cur_cols = COUNT_RESET;
    int patch_r, patch_c, patch_h, patch_w;
    int words_sent   = 0;
    int quiet_cycles = 0;
    int ready_hold   = 0;
    bit calm   = 1'b0;
    bit steady = 1'b0;

    heightmap_bilinear_sampler_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // The result side alternates random bursts of ready with random stalls; calm and steady phases keep it ready.
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm || steady || $urandom_range(0, 2) != 0) begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 19);
        end else begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 10);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if (m_valid && m_ready) sb.check_word(m_data);
            if (s_valid && s_ready) sb.note_word(s_data);
            if ((m_valid && m_ready) || (s_valid && s_ready) || cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("tb_heightmap_bilinear_sampler_unit NOT OK");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic signed [COORD_BITS-1:0] to_world(int grid_idx, int frac,
                                                               int count, int limit);
        int eff;
        eff = (count < limit) ? count : limit;
        return COORD_BITS'((grid_idx - eff / 2) * CELL_SPAN + frac);
    endfunction

    function automatic int pick_frac();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return EDGE_FRAC;
            default: return $urandom_range(0, EDGE_FRAC);
        endcase
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0: return 2;
            1: return COUNT_RESET;
            2: return COUNT_TOP;
            3: return $urandom_range(0, 1);
            4: return $urandom_range(COUNT_RESET + 1, COUNT_TOP);
            5, 6: return $urandom_range(2, 16);
            default: return $urandom_range(2, 255);
        endcase
    endfunction

    // Fields that the chosen mode does not use carry random values.
    function automatic in_word_t load_word(int r, int c, int s, bit start);
        in_word_t w;
        w.mode         = MODE_LOAD;
        w.start_of_map = start;
        w.grid_row     = 8'(r);
        w.grid_column  = 8'(c);
        w.sample_value = SAMPLE_BITS'(s);
        w.query_x      = COORD_BITS'($urandom);
        w.query_z      = COORD_BITS'($urandom);
        return w;
    endfunction

    function automatic in_word_t query_word(logic signed [COORD_BITS-1:0] qx,
                                            logic signed [COORD_BITS-1:0] qz);
        in_word_t w;
        w.mode         = MODE_QUERY;
        w.start_of_map = 1'($urandom);
        w.grid_row     = 8'($urandom);
        w.grid_column  = 8'($urandom);
        w.sample_value = SAMPLE_BITS'($urandom);
        w.query_x      = qx;
        w.query_z      = qz;
        return w;
    endfunction

    // Mostly aims at the loaded patch and its rim; a query that would read a sample
    // never loaded is redrawn, and after twenty draws a point off the grid is sent.
    function automatic in_word_t random_query();
        logic signed [COORD_BITS-1:0] qx, qz;
        int n;
        for (n = 0; n < 20; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                qx = COORD_BITS'($urandom);
                qz = COORD_BITS'($urandom);
            end else begin
                qx = to_world(patch_c - 1 + $urandom_range(0, patch_w), pick_frac(),
                              cur_cols, MAX_COLUMNS);
                qz = to_world(patch_r - 1 + $urandom_range(0, patch_h), pick_frac(),
                              cur_rows, MAX_ROWS);
            end
            if (sb.query_is_defined(qx, qz)) return query_word(qx, qz);
        end
        return query_word(COORD_MIN, COORD_MIN);
    endfunction

    task automatic send_word(in_word_t w);
        if (!calm && !steady && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
        if (words_sent >= CALM_AFTER) calm = 1'b1;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    // All results are drained and the block is left to settle before its
    // counts change.
    task automatic write_counts(int rows, int cols);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= COUNT_BITS'(rows);
        @(negedge aclk);
        cfg_index <= REG_COLUMN_COUNT;
        cfg_data  <= COUNT_BITS'(cols);
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_count(REG_ROW_COUNT, COUNT_BITS'(rows));
        sb.set_count(REG_COLUMN_COUNT, COUNT_BITS'(cols));
        cur_rows = rows;
        cur_cols = cols;
    endtask

    task automatic choose_patch();
        int rows_eff, cols_eff;
        rows_eff = (cur_rows < MAX_ROWS) ? cur_rows : MAX_ROWS;
        cols_eff = (cur_cols < MAX_COLUMNS) ? cur_cols : MAX_COLUMNS;
        if (rows_eff < 2) rows_eff = 2;
        if (cols_eff < 2) cols_eff = 2;
        patch_h = $urandom_range(2, (rows_eff < 8) ? rows_eff : 8);
        patch_w = $urandom_range(2, (cols_eff < 8) ? cols_eff : 8);
        case ($urandom_range(0, 3))
            0: patch_r = 0;
            1: patch_r = rows_eff - patch_h;
            default: patch_r = $urandom_range(0, rows_eff - patch_h);
        endcase
        case ($urandom_range(0, 3))
            0: patch_c = 0;
            1: patch_c = cols_eff - patch_w;
            default: patch_c = $urandom_range(0, cols_eff - patch_w);
        endcase
    endtask

    task automatic fill_patch();
        int r, c;
        bit fresh;
        fresh = 1'($urandom);
        for (r = 0; r < patch_h; r++) begin
            for (c = 0; c < patch_w; c++) begin
                send_word(load_word(patch_r + r, patch_c + c, pick_sample(),
                                    fresh && r == 0 && c == 0));
            end
        end
    endtask

    initial begin
        int k, mix;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Points far off the grid on both sides.
        send_word(query_word(COORD_MIN, COORD_MIN));
        send_word(query_word(COORD_MAX, COORD_MAX));
        // A low corner block of zeros, then a new map at the top corner whose
        // minimum ends at 128: the old zeros drive the blend negative.
        send_word(load_word(0, 0, 0, 1'b1));
        send_word(load_word(0, 1, 0, 1'b0));
        send_word(load_word(1, 0, 0, 1'b0));
        send_word(load_word(1, 1, 0, 1'b0));
        send_word(load_word(254, 254, 255, 1'b1));
        send_word(load_word(254, 255, 255, 1'b0));
        send_word(load_word(255, 254, 255, 1'b0));
        send_word(load_word(255, 255, 128, 1'b0));
        send_word(query_word(to_world(0, 0, cur_cols, MAX_COLUMNS),
                             to_world(0, 0, cur_rows, MAX_ROWS)));
        send_word(query_word(to_world(0, EDGE_FRAC, cur_cols, MAX_COLUMNS),
                             to_world(0, EDGE_FRAC, cur_rows, MAX_ROWS)));
        send_word(query_word(to_world(254, EDGE_FRAC, cur_cols, MAX_COLUMNS),
                             to_world(254, EDGE_FRAC, cur_rows, MAX_ROWS)));
        send_word(query_word(to_world(254, 0, cur_cols, MAX_COLUMNS),
                             to_world(254, 0, cur_rows, MAX_ROWS)));
        send_word(query_word(to_world(254, 1280, cur_cols, MAX_COLUMNS),
                             to_world(254, 700, cur_rows, MAX_ROWS)));
        // Exactly on the far edge and one step below the near edge.
        send_word(query_word(to_world(255, 0, cur_cols, MAX_COLUMNS),
                             to_world(254, 5, cur_rows, MAX_ROWS)));
        send_word(query_word(to_world(-1, EDGE_FRAC, cur_cols, MAX_COLUMNS),
                             to_world(0, 0, cur_rows, MAX_ROWS)));
        send_word(load_word(0, 0, 0, 1'b0));
        send_word(query_word(to_world(0, 1280, cur_cols, MAX_COLUMNS),
                             to_world(0, 1280, cur_rows, MAX_ROWS)));

        // Smallest usable grid, then counts too small to hold a cell, then counts
        // above the store size.
        write_counts(2, 2);
        send_word(query_word(to_world(0, 100, cur_cols, MAX_COLUMNS),
                             to_world(0, 2000, cur_rows, MAX_ROWS)));
        send_word(query_word(to_world(1, 0, cur_cols, MAX_COLUMNS),
                             to_world(0, 0, cur_rows, MAX_ROWS)));
        write_counts(1, 0);
        send_word(query_word(to_world(0, 0, cur_cols, MAX_COLUMNS),
                             to_world(0, 0, cur_rows, MAX_ROWS)));
        write_counts(COUNT_TOP, 300);
        send_word(query_word(to_world(254, 2000, cur_cols, MAX_COLUMNS),
                             to_world(254, 9, cur_rows, MAX_ROWS)));

        while (words_sent < TOTAL_WORDS) begin
            write_counts(pick_count(), pick_count());
            choose_patch();
            steady = ($urandom_range(0, 3) == 0);
            fill_patch();
            mix = $urandom_range(30, 60);
            for (k = 0; k < mix && words_sent < TOTAL_WORDS; k++) begin
                if ($urandom_range(0, 39) == 0) drain_results();
                if ($urandom_range(0, 3) != 0) begin
                    send_word(random_query());
                end else if ($urandom_range(0, 9) < 7) begin
                    send_word(load_word(patch_r + $urandom_range(0, patch_h - 1),
                                        patch_c + $urandom_range(0, patch_w - 1),
                                        pick_sample(), $urandom_range(0, 15) == 0));
                end else begin
                    send_word(load_word($urandom_range(0, 255), $urandom_range(0, 255),
                                        pick_sample(), $urandom_range(0, 15) == 0));
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_heightmap_bilinear_sampler_unit OK");
        end else begin
            $display("tb_heightmap_bilinear_sampler_unit NOT OK");
        end
        $finish;
    end

endmodule
